// File: design/hkv_pkg.sv
// Shared types and constants for the hash key-value table.
package hkv_pkg;

    localparam int IndexBits = 8;
    localparam int Ways      = 4;
    localparam int Buckets   = 1 << IndexBits;
    localparam int KeyW      = 32;
    localparam int ValW      = 32;
    localparam int WayW      = (Ways > 1) ? $clog2(Ways) : 1;

    localparam logic [KeyW-1:0] GoldenMult = 32'h61C8_8647;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_NEW     = 3'd2,
        ST_UPDATED = 3'd3,
        ST_DELETED = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_READ,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [Ways-1:0]           valid;
        logic [Ways-1:0][KeyW-1:0] keys;
        logic [Ways-1:0][ValW-1:0] values;
    } t_row;

    localparam int RowW = $bits(t_row);

endpackage

// File: design/hkv_ram.sv
// Generic simple dual-port RAM with registered read.
module hkv_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/hkv_bucket_op.sv
// Bucket search and modify: match, free slot choice, new row and status.
module hkv_bucket_op (
    input  logic [1:0]                  i_mode,
    input  logic [hkv_pkg::KeyW-1:0]    i_key,
    input  logic [hkv_pkg::ValW-1:0]    i_value,
    input  hkv_pkg::t_row               i_row,
    output hkv_pkg::t_row               o_row,
    output logic                        o_we,
    output hkv_pkg::t_status            o_status,
    output logic [hkv_pkg::ValW-1:0]    o_read_value
);

    logic                     hit;
    logic [hkv_pkg::WayW-1:0] hit_idx;
    logic                     has_free;
    logic [hkv_pkg::WayW-1:0] free_idx;

    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        for (int w = hkv_pkg::Ways - 1; w >= 0; w--) begin
            if (i_row.valid[w] && (i_row.keys[w] == i_key)) begin
                hit     = 1'b1;
                hit_idx = hkv_pkg::WayW'(w);
            end
            if (!i_row.valid[w]) begin
                has_free = 1'b1;
                free_idx = hkv_pkg::WayW'(w);
            end
        end
    end

    always_comb begin
        o_row        = i_row;
        o_we         = 1'b0;
        o_status     = hkv_pkg::ST_MISS;
        o_read_value = '0;
        unique case (i_mode)
            hkv_pkg::MODE_LOOKUP: begin
                if (hit) begin
                    o_status     = hkv_pkg::ST_HIT;
                    o_read_value = i_row.values[hit_idx];
                end
            end
            hkv_pkg::MODE_INSERT: begin
                if (hit) begin
                    o_row.values[hit_idx] = i_value;
                    o_we                  = 1'b1;
                    o_status              = hkv_pkg::ST_UPDATED;
                end else if (has_free) begin
                    o_row.valid[free_idx]  = 1'b1;
                    o_row.keys[free_idx]   = i_key;
                    o_row.values[free_idx] = i_value;
                    o_we                   = 1'b1;
                    o_status               = hkv_pkg::ST_NEW;
                end else begin
                    o_status = hkv_pkg::ST_FULL;
                end
            end
            hkv_pkg::MODE_DELETE: begin
                if (hit) begin
                    o_row.valid[hit_idx] = 1'b0;
                    o_we                 = 1'b1;
                    o_status             = hkv_pkg::ST_DELETED;
                end
            end
            default: begin
                o_status = hkv_pkg::ST_MISS;
            end
        endcase
    end

endmodule

// File: design/hash_key_value_table_unit.sv
// Top level of the hash key-value table: control, hashing, bucket memory.
//
// Input channel: i_in_valid / o_in_stall carry one request beat (i_mode,
// i_key, i_new_value). Output channel: o_out_valid / i_out_stall carry one
// result beat (o_status, o_read_value) per request.
// Each request passes through accept, hash multiply, bucket row read
// (registered memory read), then compare, write-back and result load.
// A new request is accepted only once the previous one is done;
// o_in_stall is high while a request is in flight, since each one does a
// read-modify-write of its bucket row through the single memory port pair.
// The result sits in an output register, so the next request can be taken
// while a result waits. If that register is still full and stalled when
// the next result is ready, the block holds in its execute step until
// the receiver takes the waiting beat.
// Reset clears all row-present flags (one per bucket), so every bucket
// reads as empty right after reset; no clearing pass is needed. Reset
// also empties the output register and returns control to idle.
module hash_key_value_table_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_new_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_read_value
);

    hkv_pkg::t_state r_state;
    hkv_pkg::t_state n_state;

    logic [1:0]                    r_mode;
    logic [hkv_pkg::KeyW-1:0]      r_key;
    logic [hkv_pkg::ValW-1:0]      r_value;
    logic [hkv_pkg::IndexBits-1:0] r_bucket;
    logic [hkv_pkg::Buckets-1:0]   r_row_init;
    logic                          r_row_ok;

    logic                     r_out_valid;
    hkv_pkg::t_status         r_status;
    logic [hkv_pkg::ValW-1:0] r_read_value;

    logic                     accept;
    logic                     out_free;
    logic                     ram_re;
    logic                     ram_we;
    logic                     out_load;
    logic [hkv_pkg::KeyW-1:0] prod;
    logic [hkv_pkg::RowW-1:0] ram_rdata;
    hkv_pkg::t_row            cur_row;
    hkv_pkg::t_row            new_row;
    logic                     op_we;
    hkv_pkg::t_status         op_status;
    logic [hkv_pkg::ValW-1:0] op_read_value;

    assign accept   = i_in_valid && (r_state == hkv_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign prod     = r_key * hkv_pkg::GoldenMult;

    always_comb begin
        cur_row = hkv_pkg::t_row'(ram_rdata);
        if (!r_row_ok) begin
            cur_row.valid = '0;
        end
    end

    hkv_bucket_op u_bucket_op (
        .i_mode       (r_mode),
        .i_key        (r_key),
        .i_value      (r_value),
        .i_row        (cur_row),
        .o_row        (new_row),
        .o_we         (op_we),
        .o_status     (op_status),
        .o_read_value (op_read_value)
    );

    hkv_ram #(
        .Width (hkv_pkg::RowW),
        .Depth (hkv_pkg::Buckets)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_bucket),
        .i_wdata (new_row),
        .i_re    (ram_re),
        .i_raddr (r_bucket),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state  = r_state;
        ram_re   = 1'b0;
        ram_we   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            hkv_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = hkv_pkg::S_HASH;
                end
            end
            hkv_pkg::S_HASH: begin
                n_state = hkv_pkg::S_READ;
            end
            hkv_pkg::S_READ: begin
                ram_re  = 1'b1;
                n_state = hkv_pkg::S_EXEC;
            end
            hkv_pkg::S_EXEC: begin
                if (out_free) begin
                    ram_we   = op_we;
                    out_load = 1'b1;
                    n_state  = hkv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hkv_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hkv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_key   <= i_key;
            r_value <= i_new_value;
        end
        if (r_state == hkv_pkg::S_HASH) begin
            r_bucket <= prod[hkv_pkg::KeyW-1 -: hkv_pkg::IndexBits];
        end
        if (ram_re) begin
            r_row_ok <= r_row_init[r_bucket];
        end
        if (out_load) begin
            r_status     <= op_status;
            r_read_value <= op_read_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_init  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ram_we) begin
                r_row_init[r_bucket] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall   = (r_state != hkv_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;

endmodule
